// ===== sv/tcag_pkg.sv =====
package tcag_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LOW_RATE     = 3'd0,
    REG_CEIL_RATE    = 3'd1,
    REG_STRICTNESS   = 3'd2,
    REG_HOLD_SECONDS = 3'd3,
    REG_ALT_ACTIVITY = 3'd4
  } reg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [16:0] STRICT_RST = 17'd45875;
  localparam logic [15:0] HOLD_RST   = 16'd30;

  // Q1.16 constants of the grade.
  localparam logic [16:0] Q_ONE  = 17'h10000;
  localparam logic [16:0] Q_HALF = 17'h08000;

  // Milliseconds to seconds scale.
  localparam logic [9:0] RATE_SCALE = 10'd1000;

  // Serial divider geometry.
  localparam int unsigned DIV_NUM_W = 74;
  localparam int unsigned DIV_DEN_W = 48;
  localparam int unsigned DIV_CNT_W = 7;
  localparam logic [DIV_CNT_W-1:0] RATE_STEPS  = 7'd74;
  localparam logic [DIV_CNT_W-1:0] GRADE_STEPS = 7'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RATE_START,
    ST_RATE_DIV,
    ST_SPAN_MUL,
    ST_REST_MUL,
    ST_GRADE_SEL,
    ST_GRADE_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_DEN_W-1:0] rem_init;
    logic [DIV_NUM_W-1:0] num_init;
    logic [DIV_DEN_W-1:0] den;
  } div_ctl_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic        ovf;
    logic [31:0] quo;
  } div_sts_t;

  typedef struct packed {
    logic [63:0] bits;
    logic        active;
  } trk_sts_t;

endpackage

// ===== sv/tcag_ifs.sv =====
interface tcag_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] byte_count;
  logic [39:0] now_seconds;
  logic [15:0] round_ms;
  logic        shaping_installed;
  logic [63:0] alt_byte_sum;

  modport source (
    output valid, byte_count, now_seconds, round_ms, shaping_installed, alt_byte_sum,
    input  ready
  );
  modport sink (
    input  valid, byte_count, now_seconds, round_ms, shaping_installed, alt_byte_sum,
    output ready
  );
endinterface

interface tcag_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] traffic_bps;
  logic [16:0] grade;
  logic        is_active;

  modport source (
    output valid, traffic_bps, grade, is_active,
    input  ready
  );
  modport sink (
    input  valid, traffic_bps, grade, is_active,
    output ready
  );
endinterface

// ===== sv/traffic_class_activity_grader.sv =====
// Traffic class activity grader. Each input beat is one measurement round. It
// updates the class activity state at once and returns one result beat with the
// rate in bits per second, a Q1.16 grade and the activity flag. A round scales
// the bit count by 1000 and starts the divider, runs the 74 bit-serial divider
// steps until the done flag, forms the grade products and selects the knee,
// runs the divider a second time on a slope of the grade curve, and loads the
// output register once it is free. Only one round is in flight. The input is
// ready again in the cycle after the result register is loaded. A finished
// result waits in the output register while the next round is accepted. The
// user must write configuration through cfg_we, cfg_index and cfg_data only
// while no round is in flight; the block itself does not enforce this.
module traffic_class_activity_grader
  import tcag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tcag_in_if.sink               in_if,
  tcag_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [31:0] low_r, ceil_r;
  logic [16:0] strict_r;
  logic [15:0] hold_r;
  logic        alt_r;

  logic [63:0] bits_r, bits_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic        act_r, act_nxt;
  logic [41:0] prod_lo_r, prod_lo_nxt;
  logic [41:0] prod_hi_r, prod_hi_nxt;
  logic [31:0] traffic_r, traffic_nxt;
  logic [47:0] ss_r, ss_nxt;
  logic [47:0] sc_r, sc_nxt;
  logic [16:0] gbase_r, gbase_nxt;
  logic [16:0] grade_r, grade_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_traffic_r, out_traffic_nxt;
  logic [16:0] out_grade_r, out_grade_nxt;
  logic        out_active_r, out_active_nxt;

  logic        in_accept;
  trk_sts_t    trk;
  div_ctl_t    div_ctl;
  div_sts_t    div_sts;

  logic [31:0] span;
  logic [16:0] s_c;
  logic [31:0] d;
  logic [47:0] num;

  assign in_accept    = in_if.valid && (state_r == ST_IDLE);
  assign in_if.ready  = (state_r == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= '0;
      ceil_r   <= '0;
      strict_r <= STRICT_RST;
      hold_r   <= HOLD_RST;
      alt_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_RATE:     low_r    <= cfg_data;
        REG_CEIL_RATE:    ceil_r   <= cfg_data;
        REG_STRICTNESS:   strict_r <= cfg_data[16:0];
        REG_HOLD_SECONDS: hold_r   <= cfg_data[15:0];
        REG_ALT_ACTIVITY: alt_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tcag_track u_track (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (in_accept),
    .byte_count        (in_if.byte_count),
    .now_seconds       (in_if.now_seconds),
    .shaping_installed (in_if.shaping_installed),
    .alt_byte_sum      (in_if.alt_byte_sum),
    .hold_seconds      (hold_r),
    .alt_activity      (alt_r),
    .sts               (trk)
  );

  tcag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .sts   (div_sts)
  );

  // Grade curve operands.
  assign span = ceil_r - low_r;
  assign s_c  = (strict_r > Q_ONE) ? Q_ONE : strict_r;
  assign d    = traffic_r - low_r;
  assign num  = {d, 16'b0} - ss_r;

  // Round sequencer.
  always_comb begin
    state_nxt       = state_r;
    bits_nxt        = bits_r;
    ms_nxt          = ms_r;
    act_nxt         = act_r;
    prod_lo_nxt     = prod_lo_r;
    prod_hi_nxt     = prod_hi_r;
    traffic_nxt     = traffic_r;
    ss_nxt          = ss_r;
    sc_nxt          = sc_r;
    gbase_nxt       = gbase_r;
    grade_nxt       = grade_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_traffic_nxt = out_traffic_r;
    out_grade_nxt   = out_grade_r;
    out_active_nxt  = out_active_r;
    div_ctl         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          bits_nxt  = trk.bits;
          ms_nxt    = (in_if.round_ms == '0) ? 16'd1 : in_if.round_ms;
          act_nxt   = trk.active;
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        prod_lo_nxt = 42'(bits_r[31:0]) * 42'(RATE_SCALE);
        state_nxt   = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        prod_hi_nxt = 42'(bits_r[63:32]) * 42'(RATE_SCALE);
        state_nxt   = ST_RATE_START;
      end
      ST_RATE_START: begin
        div_ctl.start    = 1'b1;
        div_ctl.steps    = RATE_STEPS;
        div_ctl.rem_init = '0;
        div_ctl.num_init = {prod_hi_r, 32'b0} + {32'b0, prod_lo_r};
        div_ctl.den      = {32'b0, ms_r};
        state_nxt        = ST_RATE_DIV;
      end
      ST_RATE_DIV: begin
        if (div_sts.done) begin
          traffic_nxt = div_sts.ovf ? 32'hFFFF_FFFF : div_sts.quo;
          state_nxt   = ST_SPAN_MUL;
        end
      end
      ST_SPAN_MUL: begin
        ss_nxt    = {16'b0, span} * {31'b0, s_c};
        state_nxt = ST_REST_MUL;
      end
      ST_REST_MUL: begin
        sc_nxt    = {16'b0, span} * {31'b0, Q_ONE - s_c};
        state_nxt = ST_GRADE_SEL;
      end
      ST_GRADE_SEL: begin
        priority if (traffic_r <= low_r) begin
          grade_nxt = '0;
          state_nxt = ST_OUT;
        end else if (ceil_r <= low_r) begin
          grade_nxt = Q_ONE;
          state_nxt = ST_OUT;
        end else if (d <= ss_r[47:16]) begin
          // Lower slope: (d << 31) / (s * span).
          div_ctl.start    = 1'b1;
          div_ctl.steps    = GRADE_STEPS;
          div_ctl.rem_init = {1'b0, d, 15'b0};
          div_ctl.num_init = '0;
          div_ctl.den      = ss_r;
          gbase_nxt        = '0;
          state_nxt        = ST_GRADE_DIV;
        end else if (traffic_r < ceil_r) begin
          // Upper slope: half plus (num << 15) / ((1 - s) * span).
          div_ctl.start    = 1'b1;
          div_ctl.steps    = GRADE_STEPS;
          div_ctl.rem_init = {1'b0, num[47:1]};
          div_ctl.num_init = {num[0], 15'b0, 58'b0};
          div_ctl.den      = sc_r;
          gbase_nxt        = Q_HALF;
          state_nxt        = ST_GRADE_DIV;
        end else begin
          grade_nxt = Q_ONE;
          state_nxt = ST_OUT;
        end
      end
      ST_GRADE_DIV: begin
        if (div_sts.done) begin
          grade_nxt = gbase_r + div_sts.quo[16:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt   = 1'b1;
          out_traffic_nxt = traffic_r;
          out_grade_nxt   = grade_r;
          out_active_nxt  = act_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r        <= bits_nxt;
    ms_r          <= ms_nxt;
    act_r         <= act_nxt;
    prod_lo_r     <= prod_lo_nxt;
    prod_hi_r     <= prod_hi_nxt;
    traffic_r     <= traffic_nxt;
    ss_r          <= ss_nxt;
    sc_r          <= sc_nxt;
    gbase_r       <= gbase_nxt;
    grade_r       <= grade_nxt;
    out_traffic_r <= out_traffic_nxt;
    out_grade_r   <= out_grade_nxt;
    out_active_r  <= out_active_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.traffic_bps = out_traffic_r;
  assign out_if.grade       = out_grade_r;
  assign out_if.is_active   = out_active_r;

  // An accepted beat always starts the rate scaling.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_MUL_LO)
    else $error("accepted beat did not start a round");

  // The divider finishes only in a state that waits for it.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_RATE_DIV || state_r == ST_GRADE_DIV))
    else $error("divider finished outside a wait state");

  // A delivered grade never exceeds one.
  a_grade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_grade_r <= Q_ONE)
    else $error("grade above one");

endmodule

// ===== sv/tcag_div.sv =====
module tcag_div
  import tcag_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_ctl_t ctl,
  output div_sts_t sts
);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;

  logic [DIV_DEN_W:0]   shifted;
  logic                 ge;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  assign shifted = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      num_nxt = ctl.num_init;
      den_nxt = ctl.den;
      rem_nxt = ctl.rem_init;
      quo_nxt = '0;
      ovf_nxt = 1'b0;
      cnt_nxt = ctl.steps;
    end else if (cnt_r != '0) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
      rem_nxt = ge ? DIV_DEN_W'(shifted - {1'b0, den_r}) : shifted[DIV_DEN_W-1:0];
      // Quotient bits beyond 32 only mark overflow.
      quo_nxt  = {quo_r[30:0], ge};
      ovf_nxt  = ovf_r | quo_r[31];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign sts.quo  = quo_r;

  // A new division starts only when the previous one has finished.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !sts.busy)
    else $error("divider started while busy");

  // The last step raises done in the next cycle.
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == DIV_CNT_W'(1) && !ctl.start) |=> done_r)
    else $error("divider missed done");

  // Done follows only a running division.
  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r == DIV_CNT_W'(1)))
    else $error("spurious divider done");

endmodule

// ===== sv/tcag_track.sv =====
module tcag_track
  import tcag_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [63:0] byte_count,
  input  logic [39:0] now_seconds,
  input  logic        shaping_installed,
  input  logic [63:0] alt_byte_sum,
  input  logic [15:0] hold_seconds,
  input  logic        alt_activity,
  output trk_sts_t    sts
);

  logic [63:0] count_r, count_nxt;
  logic        active_r, active_nxt;
  logic [39:0] seen_r, seen_nxt;

  logic [63:0] diff;
  logic        moved;
  logic [39:0] idle;
  logic        expired;

  // Bits in the round are eight times the modular counter difference.
  assign diff    = byte_count - count_r;
  assign moved   = |diff[60:0];
  assign idle    = now_seconds - seen_r;
  assign expired = active_r && (hold_seconds != '0) && (idle >= {24'b0, hold_seconds});

  always_comb begin
    count_nxt  = count_r;
    active_nxt = active_r;
    seen_nxt   = seen_r;
    if (accept) begin
      count_nxt = byte_count;
      priority if (moved) begin
        active_nxt = 1'b1;
        seen_nxt   = now_seconds;
        if (!shaping_installed) begin
          count_nxt = '0;
        end
      end else if (expired) begin
        active_nxt = 1'b0;
        count_nxt  = alt_activity ? alt_byte_sum : '0;
      end else begin
        count_nxt = byte_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      active_r <= 1'b0;
      seen_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      active_r <= active_nxt;
      seen_r   <= seen_nxt;
    end
  end

  assign sts.bits   = {diff[60:0], 3'b000};
  assign sts.active = active_nxt;

endmodule
